// ===== rtl/pip_pkg.sv =====
// pip_pkg: shared types and constants for the point-in-polygon block.
// Used by pip_cell and point_in_polygon_with_holes; depends on nothing.
package pip_pkg;

    // Sizing
    localparam int MAX_EDGES = 256;
    localparam int MAX_RINGS = 8;
    localparam int COORD_W   = 16;

    localparam int CNT_W  = $clog2(MAX_EDGES + 1);
    localparam int RING_W = (MAX_RINGS > 1) ? $clog2(MAX_RINGS) : 1;
    localparam int WIND_W = $clog2(MAX_EDGES + 1) + 1;
    localparam int DIFF_W = COORD_W + 1;
    localparam int PROD_W = 2 * DIFF_W;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic        [WIND_W-1:0]  wind_t;
    typedef logic        [RING_W-1:0]  ring_t;
    typedef logic        [CNT_W-1:0]   cnt_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } vert_t;

    // One directed edge as held in a cell
    typedef struct packed {
        vert_t a;
        vert_t b;
        ring_t ring;
    } edge_t;

    // Query token passed down the chain
    typedef struct packed {
        vert_t                     pt;
        cnt_t                      left;
        wind_t [MAX_RINGS-1:0]     wind;
    } tok_t;

    // Item actions
    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_LOAD  = 2'd1,
        ACT_QUERY = 2'd2
    } action_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD2,
        ST_QUERY
    } state_t;

endpackage

// ===== rtl/pip_cell.sv =====
// pip_cell: one edge cell of the chain. Holds one edge, shifts it on to
// the next cell on a load, and adds its winding term to a passing query.
// Depends on pip_pkg.
module pip_cell
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift_en,
    input  pip_pkg::edge_t  edge_in,
    output pip_pkg::edge_t  edge_out,
    input  logic            tok_vld_in,
    input  pip_pkg::tok_t   tok_in,
    output logic            tok_vld_out,
    output pip_pkg::tok_t   tok_out
);

    pip_pkg::edge_t edge_reg;

    // stage 1 registers
    logic           vld1_reg;
    pip_pkg::tok_t  tok1_reg;
    pip_pkg::prod_t lhs_reg;
    pip_pkg::prod_t rhs_reg;
    logic           up_reg;
    logic           dn_reg;
    logic           act_reg;

    // stage 2 registers
    logic           vld2_reg;
    pip_pkg::tok_t  tok2_reg;

    pip_pkg::diff_t dx, dy, dpx, dpy;
    pip_pkg::prod_t lhs, rhs;
    pip_pkg::tok_t  tok1_next;
    pip_pkg::tok_t  tok2_next;
    logic           act;
    logic           plus_one;
    logic           minus_one;

    // Edge store: shifts one place along the chain on a load
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            edge_reg <= edge_in;
        end
    end

    assign edge_out = edge_reg;

    // Stage 1: cross-product terms and crossing conditions
    always_comb
    begin
        dx  = pip_pkg::diff_t'(edge_reg.b.x) - pip_pkg::diff_t'(edge_reg.a.x);
        dy  = pip_pkg::diff_t'(edge_reg.b.y) - pip_pkg::diff_t'(edge_reg.a.y);
        dpx = pip_pkg::diff_t'(tok_in.pt.x)  - pip_pkg::diff_t'(edge_reg.a.x);
        dpy = pip_pkg::diff_t'(tok_in.pt.y)  - pip_pkg::diff_t'(edge_reg.a.y);
        lhs = dx * dpy;
        rhs = dpx * dy;
        act = (tok_in.left != '0);
        tok1_next = tok_in;
        tok1_next.left = act ? (tok_in.left - pip_pkg::cnt_t'(1)) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= tok_vld_in;
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_vld_in)
        begin
            tok1_reg <= tok1_next;
            lhs_reg  <= lhs;
            rhs_reg  <= rhs;
            up_reg   <= (edge_reg.a.y <= tok_in.pt.y) && (edge_reg.b.y > tok_in.pt.y);
            dn_reg   <= (edge_reg.a.y > tok_in.pt.y) && (edge_reg.b.y <= tok_in.pt.y);
            act_reg  <= act;
        end
    end

    // Stage 2: compare and bump this edge's ring counter
    always_comb
    begin
        plus_one  = act_reg && up_reg && (lhs_reg > rhs_reg);
        minus_one = act_reg && dn_reg && (lhs_reg < rhs_reg);
        tok2_next = tok1_reg;
        for (int r = 0; r < pip_pkg::MAX_RINGS; r++)
        begin
            if (edge_reg.ring == pip_pkg::ring_t'(r))
            begin
                if (plus_one)
                begin
                    tok2_next.wind[r] = tok1_reg.wind[r] + pip_pkg::wind_t'(1);
                end
                else if (minus_one)
                begin
                    tok2_next.wind[r] = tok1_reg.wind[r] - pip_pkg::wind_t'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (vld1_reg)
        begin
            tok2_reg <= tok2_next;
        end
    end

    assign tok_vld_out = vld2_reg;
    assign tok_out     = tok2_reg;

endmodule

// ===== rtl/point_in_polygon_with_holes.sv =====
// point_in_polygon_with_holes: top level. Ring bookkeeping, edge load
// control and a chain of pip_cell edge cells for winding-number queries.
// Depends on pip_pkg and pip_cell.
//
//  channel   handshake            beat contents
//  -------   ------------------   -------------------------------------------
//  input     start & !busy        action, coord_x, coord_y, ring_id, ring_end
//  result    done (one cycle)     inside_res, overflowed
//
// A clear leaves busy low. A load shifts the edge chain once per edge that it
// adds; when it adds two, the ring's closing edge is shifted in ST_LOAD2. A
// query runs its token through all MAX_EDGES cells, two register stages each;
// done is registered from the last cell's output and busy falls as done rises,
// so the next input beat can be taken with the result beat.
// Reset (rst_n, async) empties the store. The result cannot be stalled.
module point_in_polygon_with_holes
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [15:0] coord_x,
    input  logic [15:0] coord_y,
    input  logic [2:0]  ring_id,
    input  logic        ring_end,
    output logic        done,
    output logic        inside_res,
    output logic        overflowed
);

    localparam int N = pip_pkg::MAX_EDGES;

    pip_pkg::state_t state_reg, state_next;
    pip_pkg::cnt_t   count_reg, count_next;
    pip_pkg::vert_t  first_reg, first_next;
    pip_pkg::vert_t  prev_reg,  prev_next;
    logic            open_reg,  open_next;
    logic            ovf_reg,   ovf_next;
    pip_pkg::edge_t  pend_reg,  pend_next;
    logic            done_reg,  done_next;
    logic            inside_reg, inside_next;
    logic            ovf_out_reg;

    logic            shift_en;
    pip_pkg::edge_t  shift_edge;
    logic            tok_vld0;
    pip_pkg::tok_t   tok0;

    pip_pkg::edge_t  edge_chain [0:N];
    logic            vld_chain  [0:N];
    pip_pkg::tok_t   tok_chain  [0:N];

    pip_pkg::vert_t  v;
    pip_pkg::edge_t  e_prev, e_close;
    logic            ring_ok;
    logic            room;
    logic            holes_clear;

    // Incoming vertex and the edges it may add
    always_comb
    begin
        v.x       = pip_pkg::coord_t'(coord_x[pip_pkg::COORD_W-1:0]);
        v.y       = pip_pkg::coord_t'(coord_y[pip_pkg::COORD_W-1:0]);
        ring_ok   = (int'(ring_id) < pip_pkg::MAX_RINGS);
        e_prev.a  = prev_reg;
        e_prev.b  = v;
        e_prev.ring  = pip_pkg::ring_t'(ring_id);
        e_close.a = v;
        e_close.b = open_reg ? first_reg : v;
        e_close.ring = pip_pkg::ring_t'(ring_id);
        room      = (count_reg < pip_pkg::cnt_t'(N));
    end

    // Final check on the token leaving the chain
    always_comb
    begin
        holes_clear = 1'b1;
        for (int r = 1; r < pip_pkg::MAX_RINGS; r++)
        begin
            if (tok_chain[N].wind[r] != '0)
            begin
                holes_clear = 1'b0;
            end
        end
    end

    // Controller: next state, bookkeeping and chain control
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        first_next  = first_reg;
        prev_next   = prev_reg;
        open_next   = open_reg;
        ovf_next    = ovf_reg;
        pend_next   = pend_reg;
        shift_en    = 1'b0;
        shift_edge  = pend_reg;
        tok_vld0    = 1'b0;
        tok0.pt     = v;
        tok0.left   = count_reg;
        tok0.wind   = '0;
        done_next   = 1'b0;
        inside_next = 1'b0;

        unique case (state_reg)
            pip_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    unique case (pip_pkg::action_t'(action))
                        pip_pkg::ACT_CLEAR:
                        begin
                            count_next = '0;
                            open_next  = 1'b0;
                            ovf_next   = 1'b0;
                        end
                        pip_pkg::ACT_LOAD:
                        begin
                            if (ring_ok)
                            begin
                                if (open_reg)
                                begin
                                    shift_edge = e_prev;
                                    if (room)
                                    begin
                                        shift_en   = 1'b1;
                                        count_next = count_reg + pip_pkg::cnt_t'(1);
                                    end
                                    else
                                    begin
                                        ovf_next = 1'b1;
                                    end
                                    if (ring_end)
                                    begin
                                        pend_next  = e_close;
                                        state_next = pip_pkg::ST_LOAD2;
                                    end
                                end
                                else
                                begin
                                    first_next = v;
                                    if (ring_end)
                                    begin
                                        shift_edge = e_close;
                                        if (room)
                                        begin
                                            shift_en   = 1'b1;
                                            count_next = count_reg + pip_pkg::cnt_t'(1);
                                        end
                                        else
                                        begin
                                            ovf_next = 1'b1;
                                        end
                                    end
                                end
                                prev_next = v;
                                open_next = !ring_end;
                            end
                        end
                        pip_pkg::ACT_QUERY:
                        begin
                            tok_vld0   = 1'b1;
                            state_next = pip_pkg::ST_QUERY;
                        end
                        default:
                        begin
                            state_next = pip_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            pip_pkg::ST_LOAD2:
            begin
                // closing edge of a ring
                if (room)
                begin
                    shift_en   = 1'b1;
                    count_next = count_reg + pip_pkg::cnt_t'(1);
                end
                else
                begin
                    ovf_next = 1'b1;
                end
                state_next = pip_pkg::ST_IDLE;
            end
            pip_pkg::ST_QUERY:
            begin
                if (vld_chain[N])
                begin
                    done_next   = 1'b1;
                    inside_next = (count_reg != '0) && (tok_chain[N].wind[0] != '0)
                                  && holes_clear;
                    state_next  = pip_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pip_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pip_pkg::ST_IDLE;
            count_reg <= '0;
            first_reg <= '0;
            prev_reg  <= '0;
            open_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            first_reg <= first_next;
            prev_reg  <= prev_next;
            open_reg  <= open_next;
            ovf_reg   <= ovf_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        if (done_next)
        begin
            inside_reg  <= inside_next;
            ovf_out_reg <= ovf_reg;
        end
    end

    // Edge cell chain
    assign edge_chain[0] = shift_edge;
    assign vld_chain[0]  = tok_vld0;
    assign tok_chain[0]  = tok0;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        pip_cell u_cell
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .shift_en    (shift_en),
            .edge_in     (edge_chain[i]),
            .edge_out    (edge_chain[i+1]),
            .tok_vld_in  (vld_chain[i]),
            .tok_in      (tok_chain[i]),
            .tok_vld_out (vld_chain[i+1]),
            .tok_out     (tok_chain[i+1])
        );
    end

    assign busy       = (state_reg != pip_pkg::ST_IDLE);
    assign done       = done_reg;
    assign inside_res = inside_reg;
    assign overflowed = ovf_out_reg;

endmodule
